@@ hw/rtl/nirpd_pkg.sv @@
`default_nettype none
package nirpd_pkg;

	localparam int FRAME_BITS = 32;
	localparam int CNT_W = $clog2(FRAME_BITS + 1);
	localparam int IDX_W = $clog2(FRAME_BITS);
	localparam int DUR_W = 16;

	localparam int LEADER_MARK = 9000;
	localparam int LEADER_SPACE = 4500;
	localparam int REPEAT_SPACE = 2250;
	localparam int BIT_MARK = 560;
	localparam int ZERO_SPACE = 560;
	localparam int ONE_SPACE = 1690;
	localparam int WIN_LO_PCT = 70;
	localparam int WIN_HI_PCT = 130;
	localparam int PCT = 100;

	localparam logic [DUR_W-1:0] LEADER_MARK_LO = DUR_W'((LEADER_MARK * WIN_LO_PCT) / PCT);
	localparam logic [DUR_W-1:0] LEADER_MARK_HI = DUR_W'((LEADER_MARK * WIN_HI_PCT) / PCT);
	localparam logic [DUR_W-1:0] LEADER_SPACE_LO = DUR_W'((LEADER_SPACE * WIN_LO_PCT) / PCT);
	localparam logic [DUR_W-1:0] LEADER_SPACE_HI = DUR_W'((LEADER_SPACE * WIN_HI_PCT) / PCT);
	localparam logic [DUR_W-1:0] REPEAT_SPACE_LO = DUR_W'((REPEAT_SPACE * WIN_LO_PCT) / PCT);
	localparam logic [DUR_W-1:0] REPEAT_SPACE_HI = DUR_W'((REPEAT_SPACE * WIN_HI_PCT) / PCT);
	localparam logic [DUR_W-1:0] BIT_MARK_LO = DUR_W'((BIT_MARK * WIN_LO_PCT) / PCT);
	localparam logic [DUR_W-1:0] BIT_MARK_HI = DUR_W'((BIT_MARK * WIN_HI_PCT) / PCT);
	localparam logic [DUR_W-1:0] ZERO_SPACE_LO = DUR_W'((ZERO_SPACE * WIN_LO_PCT) / PCT);
	localparam logic [DUR_W-1:0] ZERO_SPACE_HI = DUR_W'((ZERO_SPACE * WIN_HI_PCT) / PCT);
	localparam logic [DUR_W-1:0] ONE_SPACE_LO = DUR_W'((ONE_SPACE * WIN_LO_PCT) / PCT);
	localparam logic [DUR_W-1:0] ONE_SPACE_HI = DUR_W'((ONE_SPACE * WIN_HI_PCT) / PCT);

	localparam logic [15:0] SETTOP_ADDR_RESET = 16'd34798;
	localparam logic [6:0] CMD7_MASK = 7'h7F;

	typedef enum logic [1:0] {
		KIND_MARK = 2'd0,
		KIND_SPACE = 2'd1,
		KIND_TIMEOUT = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_NONE = 2'd0,
		ST_FRAME = 2'd1,
		ST_REPEAT = 2'd2,
		ST_ERROR = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		VAR_PLAIN = 2'd0,
		VAR_EXTENDED = 2'd1,
		VAR_SETTOP = 2'd2,
		VAR_UNUSED = 2'd3
	} variant_t;

	typedef enum logic [1:0] {
		REG_VARIANT = 2'd0,
		REG_SETTOP_ADDR = 2'd1
	} reg_index_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_LEADER_SPACE = 3'd1,
		PH_REPEAT_MARK = 3'd2,
		PH_BIT_MARK = 3'd3,
		PH_BIT_SPACE = 3'd4
	} phase_t;

	// classified event, kind already folded in
	typedef struct packed {
		logic timeout;
		logic leader_mark;
		logic leader_space;
		logic repeat_space;
		logic bit_mark;
		logic zero_space;
		logic one_space;
	} match_t;

	typedef struct packed {
		status_t status;
		logic [FRAME_BITS-1:0] raw;
	} step_t;

	function automatic logic [7:0] rev8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7-i];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/nirpd_classify.sv @@
`default_nettype none
module nirpd_classify (
	input  wire logic [1:0]  kind,
	input  wire logic [15:0] duration,
	output nirpd_pkg::match_t match
);

	logic is_mark;
	logic is_space;

	function automatic logic hit(input logic [15:0] d, input logic [15:0] lo,
			input logic [15:0] hi);
		return (d >= lo) && (d <= hi);
	endfunction

	assign is_mark = (kind == nirpd_pkg::KIND_MARK);
	assign is_space = (kind == nirpd_pkg::KIND_SPACE);

	always_comb begin
		match.timeout = (kind == nirpd_pkg::KIND_TIMEOUT);
		match.leader_mark = is_mark &&
			hit(duration, nirpd_pkg::LEADER_MARK_LO, nirpd_pkg::LEADER_MARK_HI);
		match.leader_space = is_space &&
			hit(duration, nirpd_pkg::LEADER_SPACE_LO, nirpd_pkg::LEADER_SPACE_HI);
		match.repeat_space = is_space &&
			hit(duration, nirpd_pkg::REPEAT_SPACE_LO, nirpd_pkg::REPEAT_SPACE_HI);
		match.bit_mark = is_mark &&
			hit(duration, nirpd_pkg::BIT_MARK_LO, nirpd_pkg::BIT_MARK_HI);
		match.zero_space = is_space &&
			hit(duration, nirpd_pkg::ZERO_SPACE_LO, nirpd_pkg::ZERO_SPACE_HI);
		match.one_space = is_space &&
			hit(duration, nirpd_pkg::ONE_SPACE_LO, nirpd_pkg::ONE_SPACE_HI);
	end

endmodule
`default_nettype wire

@@ hw/rtl/nirpd_fsm.sv @@
`default_nettype none
module nirpd_fsm (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire nirpd_pkg::match_t match,
	output nirpd_pkg::step_t      result
);

	nirpd_pkg::phase_t phase_q, phase_d;
	logic [nirpd_pkg::CNT_W-1:0] bits_q, bits_d;
	logic [nirpd_pkg::FRAME_BITS-1:0] shift_q, shift_d;
	logic [nirpd_pkg::CNT_W-1:0] bits_inc;
	logic [nirpd_pkg::FRAME_BITS-1:0] shift_set;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= nirpd_pkg::PH_IDLE;
			bits_q <= '0;
			shift_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			bits_q <= bits_d;
			shift_q <= shift_d;
		end
	end

	assign bits_inc = bits_q + nirpd_pkg::CNT_W'(1);

	always_comb begin
		shift_set = shift_q;
		shift_set[bits_q[nirpd_pkg::IDX_W-1:0]] = 1'b1;
	end

	always_comb begin
		phase_d = nirpd_pkg::PH_IDLE;
		bits_d = '0;
		shift_d = '0;
		result.status = nirpd_pkg::ST_NONE;
		result.raw = '0;
		if (match.timeout) begin
			phase_d = nirpd_pkg::PH_IDLE;
		end else begin
			unique case (phase_q)
				nirpd_pkg::PH_IDLE: begin
					if (match.leader_mark) begin
						phase_d = nirpd_pkg::PH_LEADER_SPACE;
					end
				end
				nirpd_pkg::PH_LEADER_SPACE: begin
					if (match.leader_space) begin
						phase_d = nirpd_pkg::PH_BIT_MARK;
					end else if (match.repeat_space) begin
						phase_d = nirpd_pkg::PH_REPEAT_MARK;
					end else begin
						result.status = nirpd_pkg::ST_ERROR;
					end
				end
				nirpd_pkg::PH_REPEAT_MARK: begin
					result.status = match.bit_mark ? nirpd_pkg::ST_REPEAT
						: nirpd_pkg::ST_ERROR;
				end
				nirpd_pkg::PH_BIT_MARK: begin
					if (match.bit_mark) begin
						phase_d = nirpd_pkg::PH_BIT_SPACE;
						bits_d = bits_q;
						shift_d = shift_q;
					end else begin
						result.status = nirpd_pkg::ST_ERROR;
					end
				end
				nirpd_pkg::PH_BIT_SPACE: begin
					if (!match.one_space && !match.zero_space) begin
						result.status = nirpd_pkg::ST_ERROR;
					end else if (bits_inc < nirpd_pkg::CNT_W'(nirpd_pkg::FRAME_BITS)) begin
						phase_d = nirpd_pkg::PH_BIT_MARK;
						bits_d = bits_inc;
						shift_d = match.one_space ? shift_set : shift_q;
					end else begin
						result.status = nirpd_pkg::ST_FRAME;
						result.raw = match.one_space ? shift_set : shift_q;
					end
				end
				default: begin
					result.status = nirpd_pkg::ST_ERROR;
				end
			endcase
		end
	end

	// count only moves while a frame is being collected
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == nirpd_pkg::PH_IDLE) |-> (bits_q == '0 && shift_q == '0))
		else $error("idle phase with data left over");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bits_q < nirpd_pkg::CNT_W'(nirpd_pkg::FRAME_BITS))
		else $error("bit count past frame length");
	a_step_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(phase_q) && $stable(bits_q))
		else $error("decoder state moved without a word");

endmodule
`default_nettype wire

@@ hw/rtl/nirpd_check.sv @@
`default_nettype none
module nirpd_check (
	input  wire logic [nirpd_pkg::FRAME_BITS-1:0] raw,
	input  wire logic [1:0]  variant,
	input  wire logic [15:0] settop_address,
	output logic      [15:0] address,
	output logic      [7:0]  command,
	output logic             frame_ok
);

	logic [7:0] b0, b1, b2, b3;
	logic [7:0] r0, r1;
	logic cmd_good;
	logic settop_hit;

	assign b0 = raw[7:0];
	assign b1 = raw[15:8];
	assign b2 = raw[23:16];
	assign b3 = raw[31:24];
	assign r0 = nirpd_pkg::rev8(b0);
	assign r1 = nirpd_pkg::rev8(b1);
	assign cmd_good = (~b2 == b3);
	// address may arrive byte-swapped and/or bit-reversed
	assign settop_hit = ({b1, b0} == settop_address) || ({b0, b1} == settop_address) ||
		({r1, r0} == settop_address) || ({r0, r1} == settop_address);

	always_comb begin
		address = '0;
		command = '0;
		frame_ok = 1'b0;
		unique case (variant)
			nirpd_pkg::VAR_PLAIN: begin
				if (cmd_good && (~b0 == b1)) begin
					address = {8'h00, b0};
					command = b2;
					frame_ok = 1'b1;
				end
			end
			nirpd_pkg::VAR_SETTOP: begin
				if (settop_hit) begin
					address = settop_address;
					command = {1'b0, b2[7:1] & nirpd_pkg::CMD7_MASK};
					frame_ok = 1'b1;
				end
			end
			default: begin
				if (cmd_good) begin
					address = {b1, b0};
					command = b2;
					frame_ok = 1'b1;
				end
			end
		endcase
	end

endmodule
`default_nettype wire

@@ hw/rtl/nec_ir_pulse_decoder_top.sv @@
// a word taken into the input register goes through the decode pass and is presented by the result register
// throughput: one event word per cycle while out_stall does not hold the pipe, set by
//   the single decode pass between the input register and the result register
// every accepted event gives exactly one result word
// reset (arst_n low, asynchronous) empties both registers, sets the decoder idle
//   and loads variant 0 and set-top address 34798
`default_nettype none
module nec_ir_pulse_decoder_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [15:0] duration,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [31:0]      raw_frame,
	output logic [15:0]      address,
	output logic [7:0]       command,
	output logic             frame_ok,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	logic [1:0]  variant_q;
	logic [15:0] settop_addr_q;

	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [15:0] dur_s1;
	logic        valid_s2;

	logic s2_ready;
	logic s1_ready;
	logic step;

	nirpd_pkg::match_t match;
	nirpd_pkg::step_t  result;
	logic [15:0] chk_address;
	logic [7:0]  chk_command;
	logic        chk_ok;
	logic        is_frame;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= nirpd_pkg::VAR_PLAIN;
			settop_addr_q <= nirpd_pkg::SETTOP_ADDR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == nirpd_pkg::REG_VARIANT) begin
				variant_q <= cfg_data[1:0];
			end else if (cfg_index == nirpd_pkg::REG_SETTOP_ADDR) begin
				settop_addr_q <= cfg_data;
			end
		end
	end

	assign s2_ready = !valid_s2 || !out_stall;
	assign s1_ready = !valid_s1 || s2_ready;
	assign step = valid_s1 && s2_ready;
	assign in_stall = !s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && s1_ready) begin
			kind_s1 <= kind;
			dur_s1 <= duration;
		end
	end

	nirpd_classify u_classify (
		.kind     (kind_s1),
		.duration (dur_s1),
		.match    (match)
	);

	nirpd_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.match  (match),
		.result (result)
	);

	nirpd_check u_check (
		.raw            (result.raw),
		.variant        (variant_q),
		.settop_address (settop_addr_q),
		.address        (chk_address),
		.command        (chk_command),
		.frame_ok       (chk_ok)
	);

	assign is_frame = (result.status == nirpd_pkg::ST_FRAME);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	// result word, decoded fields zeroed unless the frame checks out
	always_ff @(posedge clk) begin
		if (step) begin
			status <= result.status;
			raw_frame <= result.raw;
			address <= (is_frame && chk_ok) ? chk_address : '0;
			command <= (is_frame && chk_ok) ? chk_command : '0;
			frame_ok <= is_frame && chk_ok;
		end
	end

	assign out_valid = valid_s2;

	a_ok_is_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_ok) |-> (status == nirpd_pkg::ST_FRAME))
		else $error("frame_ok without a frame");
	a_raw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != nirpd_pkg::ST_FRAME) |-> (raw_frame == '0))
		else $error("raw data on a non-frame word");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled with room in the pipe");

endmodule
`default_nettype wire
